/* hw/rtl/ipv4ov_pkg.sv */
// shared types and constants of the ipv4 options validator
// used by the front, queue, back and top-level modules; no dependencies
`default_nettype none

package ipv4ov_pkg;

  // option kinds
  localparam logic [7:0] OPT_END    = 8'd0;
  localparam logic [7:0] OPT_NOOP   = 8'd1;
  localparam logic [7:0] OPT_RR     = 8'd7;
  localparam logic [7:0] OPT_TSTAMP = 8'd68;
  localparam logic [7:0] OPT_LSRR   = 8'd131;
  localparam logic [7:0] OPT_SSRR   = 8'd137;

  // timestamp flag codes and full overflow count
  localparam logic [3:0] TSF_TIME_ONLY = 4'd0;
  localparam logic [3:0] TSF_TIME_ADDR = 4'd1;
  localparam logic [3:0] TSF_PRESPEC   = 4'd3;
  localparam logic [3:0] OVERFLOW_FULL = 4'd15;

  // seen flag bit positions
  localparam logic [1:0] SEEN_RR  = 2'd0;
  localparam logic [1:0] SEEN_TS  = 2'd1;
  localparam logic [1:0] SEEN_SRR = 2'd2;

  // header geometry
  localparam logic [5:0] HDR_MIN_BYTES = 6'd20;
  localparam logic [3:0] IHL_MIN       = 4'd5;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
  localparam logic [1:0] VERDICT_SRCROUTE  = 2'd2;

  // classified header byte passed from front to back
  typedef struct packed {
    logic [7:0] hdr_byte;
    logic [5:0] offset;
    logic [5:0] hdr_len;
    logic       last;
  } q_entry_t;

  // result item
  typedef struct packed {
    logic [5:0] problem_offset;
    logic [1:0] verdict;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/ipv4ov_front.sv */
// front end: tracks the header byte offset and header length, classifies bytes
// depends on ipv4ov_pkg
`default_nettype none

module ipv4ov_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           hdr_byte_i,
  input  wire logic                 first_i,
  output ipv4ov_pkg::q_entry_t      entry_o,
  output logic                      push_o
);

  logic [5:0] byte_count_q, byte_count_d;
  logic [5:0] header_bytes_q, header_bytes_d;
  logic [5:0] cnt_eff;
  logic [5:0] hdr_len;
  logic       in_hdr;

  // offset of this byte and header length in force for it
  always_comb begin
    cnt_eff = first_i ? 6'd0 : byte_count_q;
    in_hdr  = cnt_eff < header_bytes_q;
    if (cnt_eff == 6'd0) begin
      hdr_len = (hdr_byte_i[3:0] >= ipv4ov_pkg::IHL_MIN) ? {hdr_byte_i[3:0], 2'b00}
                                                         : ipv4ov_pkg::HDR_MIN_BYTES;
    end else begin
      hdr_len = header_bytes_q;
    end
  end

  // next counters
  always_comb begin
    byte_count_d   = byte_count_q;
    header_bytes_d = header_bytes_q;
    if (accept_i) begin
      if (first_i) begin
        byte_count_d = 6'd0;
      end
      if (in_hdr) begin
        byte_count_d   = cnt_eff + 6'd1;
        header_bytes_d = hdr_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= 6'd0;
      header_bytes_q <= ipv4ov_pkg::HDR_MIN_BYTES;
    end else begin
      byte_count_q   <= byte_count_d;
      header_bytes_q <= header_bytes_d;
    end
  end

  // bytes past the header end are dropped here
  assign push_o           = accept_i && in_hdr;
  assign entry_o.hdr_byte = hdr_byte_i;
  assign entry_o.offset   = cnt_eff;
  assign entry_o.hdr_len  = hdr_len;
  assign entry_o.last     = (cnt_eff + 6'd1) == hdr_len;

endmodule

`default_nettype wire

/* hw/rtl/ipv4ov_queue.sv */
// two-entry queue of classified header bytes between front and back
// depends on ipv4ov_pkg
`default_nettype none

module ipv4ov_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ipv4ov_pkg::q_entry_t push_entry_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output ipv4ov_pkg::q_entry_t      head_o
);

  ipv4ov_pkg::q_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hw/rtl/ipv4ov_back.sv */
// back end: option parser state and the registered result item
// depends on ipv4ov_pkg
`default_nettype none

module ipv4ov_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire ipv4ov_pkg::q_entry_t entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ipv4ov_pkg::result_t       result_o
);

  logic [7:0] kind_q, kind_d;
  logic [7:0] len_q, len_d;
  logic [7:0] ptr_q, ptr_d;
  logic [5:0] pos_q, pos_d;
  logic [5:0] start_q, start_d;
  logic [2:0] seen_q, seen_d;
  logic       done_q, done_d;
  logic [6:0] fault_q, fault_d;
  logic       out_valid_q;
  ipv4ov_pkg::result_t result_q, result_d;

  logic [5:0] left;
  logic [7:0] b;
  logic       srr;
  logic       mark;
  logic [5:0] mark_off;
  logic [8:0] p_plus3, p_plus7, b_plus3;
  logic       emit;

  // pop when the item needs no output slot or the slot is free
  assign pop_o = valid_i && (!entry_i.last || !out_valid_q || out_ready_i);
  assign emit  = pop_o && entry_i.last;

  assign b       = entry_i.hdr_byte;
  assign left    = entry_i.hdr_len - start_q;
  assign srr     = (kind_q == ipv4ov_pkg::OPT_SSRR) || (kind_q == ipv4ov_pkg::OPT_LSRR);
  assign p_plus3 = {1'b0, ptr_q} + 9'd3;
  assign p_plus7 = {1'b0, ptr_q} + 9'd7;
  assign b_plus3 = {1'b0, b} + 9'd3;

  // option parse step
  always_comb begin
    kind_d   = kind_q;
    len_d    = len_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    start_d  = start_q;
    seen_d   = seen_q;
    done_d   = done_q;
    fault_d  = fault_q;
    mark     = 1'b0;
    mark_off = 6'd0;
    if (pop_o) begin
      if (entry_i.offset == 6'd0) begin
        // new header clears the parse
        kind_d  = 8'd0;
        len_d   = 8'd0;
        ptr_d   = 8'd0;
        pos_d   = 6'd0;
        start_d = ipv4ov_pkg::HDR_MIN_BYTES;
        seen_d  = 3'd0;
        done_d  = 1'b0;
        fault_d = 7'd0;
      end else if (entry_i.offset >= ipv4ov_pkg::HDR_MIN_BYTES && !done_q) begin
        if (pos_q == 6'd0) begin
          // kind byte
          kind_d = b;
          if (b == ipv4ov_pkg::OPT_END) begin
            done_d = 1'b1;
          end else if (b == ipv4ov_pkg::OPT_NOOP) begin
            start_d = entry_i.offset + 6'd1;
          end else if (left < 6'd2) begin
            mark     = 1'b1;
            mark_off = entry_i.offset;
          end else begin
            pos_d = 6'd1;
          end
        end else begin
          if (pos_q == 6'd1) begin
            // length byte
            len_d = b;
            if (b < 8'd2 || b > {2'b00, left}) begin
              mark     = 1'b1;
              mark_off = start_q;
            end else if (srr) begin
              if (b < 8'd3) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd1;
              end
            end else if (kind_q == ipv4ov_pkg::OPT_RR) begin
              if (seen_q[ipv4ov_pkg::SEEN_RR]) begin
                mark     = 1'b1;
                mark_off = start_q;
              end else if (b < 8'd3) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd1;
              end
            end else if (kind_q == ipv4ov_pkg::OPT_TSTAMP) begin
              if (seen_q[ipv4ov_pkg::SEEN_TS]) begin
                mark     = 1'b1;
                mark_off = start_q;
              end else if (b < 8'd4) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd1;
              end
            end
          end else if (pos_q == 6'd2) begin
            // pointer byte
            ptr_d = b;
            if (srr) begin
              if (b < 8'd4) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd2;
              end else if (seen_q[ipv4ov_pkg::SEEN_SRR]) begin
                mark     = 1'b1;
                mark_off = start_q;
              end else begin
                seen_d[ipv4ov_pkg::SEEN_SRR] = 1'b1;
              end
            end else if (kind_q == ipv4ov_pkg::OPT_RR) begin
              if (b < 8'd4) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd2;
              end else if (b <= len_q && b_plus3 > {1'b0, len_q}) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd2;
              end else begin
                seen_d[ipv4ov_pkg::SEEN_RR] = 1'b1;
              end
            end else if (kind_q == ipv4ov_pkg::OPT_TSTAMP) begin
              if (b < 8'd5) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd2;
              end
            end
          end else if (pos_q == 6'd3 && kind_q == ipv4ov_pkg::OPT_TSTAMP) begin
            // timestamp flags and overflow byte
            if (ptr_q <= len_q) begin
              if (p_plus3 > {1'b0, len_q}) begin
                mark     = 1'b1;
                mark_off = start_q + 6'd2;
              end else if (b[3:0] == ipv4ov_pkg::TSF_TIME_ONLY) begin
                seen_d[ipv4ov_pkg::SEEN_TS] = 1'b1;
              end else if (b[3:0] == ipv4ov_pkg::TSF_TIME_ADDR ||
                           b[3:0] == ipv4ov_pkg::TSF_PRESPEC) begin
                if (p_plus7 > {1'b0, len_q}) begin
                  mark     = 1'b1;
                  mark_off = start_q + 6'd2;
                end else begin
                  seen_d[ipv4ov_pkg::SEEN_TS] = 1'b1;
                end
              end else begin
                mark     = 1'b1;
                mark_off = start_q + 6'd3;
              end
            end else if (b[7:4] == ipv4ov_pkg::OVERFLOW_FULL) begin
              mark     = 1'b1;
              mark_off = start_q + 6'd3;
            end else begin
              seen_d[ipv4ov_pkg::SEEN_TS] = 1'b1;
            end
          end

          // step to the next option byte or the next option
          if (mark) begin
            fault_d = {1'b1, mark_off};
            done_d  = 1'b1;
          end else if ({3'b000, pos_q} + 9'd1 >= {1'b0, len_d}) begin
            pos_d   = 6'd0;
            start_d = entry_i.offset + 6'd1;
          end else begin
            pos_d = pos_q + 6'd1;
          end
        end
        // fault on a kind byte
        if (pos_q == 6'd0 && mark) begin
          fault_d = {1'b1, mark_off};
          done_d  = 1'b1;
        end
      end
    end
  end

  // verdict from the state after this byte
  always_comb begin
    if (fault_d[6]) begin
      result_d.verdict        = ipv4ov_pkg::VERDICT_MALFORMED;
      result_d.problem_offset = fault_d[5:0];
    end else if (seen_d[ipv4ov_pkg::SEEN_SRR]) begin
      result_d.verdict        = ipv4ov_pkg::VERDICT_SRCROUTE;
      result_d.problem_offset = 6'd0;
    end else begin
      result_d.verdict        = ipv4ov_pkg::VERDICT_ACCEPT;
      result_d.problem_offset = 6'd0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= 8'd0;
      len_q       <= 8'd0;
      ptr_q       <= 8'd0;
      pos_q       <= 6'd0;
      start_q     <= ipv4ov_pkg::HDR_MIN_BYTES;
      seen_q      <= 3'd0;
      done_q      <= 1'b0;
      fault_q     <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      kind_q  <= kind_d;
      len_q   <= len_d;
      ptr_q   <= ptr_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      seen_q  <= seen_d;
      done_q  <= done_d;
      fault_q <= fault_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

/* hw/rtl/ipv4_options_validator.sv */
// top level of the ipv4 header options validator
// depends on ipv4ov_pkg, ipv4ov_front, ipv4ov_queue and ipv4ov_back
`default_nettype none

// Takes an IPv4 header one byte per item (tuser marks byte 0) and, on the last
// header byte as given by the IHL nibble, returns one verdict item: accepted,
// malformed option with the header offset of the first fault, or source route
// present. Bytes after the header end without tuser set are absorbed with no
// result. A byte is taken every cycle while the queue is not full; the front
// stage counts offsets, a two-entry queue holds classified bytes, the option
// parser in the back stage handles one byte per cycle, and a verdict item is
// offered from the result register once its last byte has left the queue.
// Throughput is one byte per cycle as long as the output side takes results
// when offered; a stalled result holds the back stage only when the next verdict is ready to leave.
module ipv4_options_validator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] hdr_byte
  input  wire logic       s_axis_tuser_i,   // [0] first
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [1:0] verdict, [7:2] problem_offset
);

  ipv4ov_pkg::q_entry_t push_entry;
  ipv4ov_pkg::q_entry_t head_entry;
  ipv4ov_pkg::result_t  result;
  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_valid;
  logic                 accept;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // offset tracking and classification
  ipv4ov_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .hdr_byte_i (s_axis_tdata_i),
    .first_i    (s_axis_tuser_i),
    .entry_o    (push_entry),
    .push_o     (push)
  );

  // decoupling queue
  ipv4ov_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (head_entry)
  );

  // option parser and result register
  ipv4ov_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = {result.problem_offset, result.verdict};

endmodule

`default_nettype wire

/* sim/ipv4ov_checker.sv */
// verdict checker for the ipv4 options validator testbench
// watches both stream channels, predicts each verdict item and compares it
// depends on ipv4ov_pkg
`timescale 1ns / 100ps

module ipv4ov_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  input  wire logic       s_axis_tready_i,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] hdr_byte
  input  wire logic       s_axis_tuser_i,   // [0] first
  input  wire logic       m_axis_tvalid_i,
  input  wire logic       m_axis_tready_i,
  input  wire logic [7:0] m_axis_tdata_i,   // [1:0] verdict, [7:2] problem_offset
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     accepted_o,
  output int unsigned     malformed_o,
  output int unsigned     srcroute_o
);

  // parser state of the predictor
  logic [5:0] byte_cnt;
  logic [5:0] hdr_len;
  logic [7:0] opt_kind;
  logic [7:0] opt_len;
  logic [7:0] opt_ptr;
  logic [5:0] opt_pos;
  logic [5:0] opt_start;
  logic [2:0] seen;
  logic       parse_done;
  logic [6:0] fault_at;     // bit 6 marks a recorded fault

  ipv4ov_pkg::result_t verdicts_due[$];
  ipv4ov_pkg::result_t res, want, got;
  bit                  due;
  int unsigned         fails, n_accept, n_malformed, n_srcroute;

  function automatic void clear_parse();
    opt_kind   = '0;
    opt_len    = '0;
    opt_ptr    = '0;
    opt_pos    = '0;
    opt_start  = ipv4ov_pkg::HDR_MIN_BYTES;
    seen       = '0;
    parse_done = 1'b0;
    fault_at   = '0;
  endfunction

  function automatic void flag_fault(input int unsigned off);
    fault_at   = {1'b1, off[5:0]};
    parse_done = 1'b1;
  endfunction

  // advance the parse by one header byte; a verdict is due on the last byte
  task automatic predict_byte(input logic [7:0] b, input logic first,
                              output bit vdue, output ipv4ov_pkg::result_t vres);
    int unsigned o, left, pos, p;
    bit srcroute;
    vdue = 1'b0;
    vres = '0;
    if (first) byte_cnt = '0;
    if (byte_cnt < hdr_len) begin
      o = byte_cnt;
      if (o == 0) begin
        // ihl below minimum is taken as a plain 20-byte header
        hdr_len = (b[3:0] >= ipv4ov_pkg::IHL_MIN) ? {b[3:0], 2'b00}
                                                  : ipv4ov_pkg::HDR_MIN_BYTES;
        clear_parse();
      end else if (o >= ipv4ov_pkg::HDR_MIN_BYTES && !parse_done) begin
        left     = hdr_len - opt_start;
        pos      = opt_pos;
        srcroute = (opt_kind == ipv4ov_pkg::OPT_SSRR) || (opt_kind == ipv4ov_pkg::OPT_LSRR);
        if (pos == 0) begin
          // option kind byte
          opt_kind = b;
          if (b == ipv4ov_pkg::OPT_END) parse_done = 1'b1;
          else if (b == ipv4ov_pkg::OPT_NOOP) opt_start = 6'(o + 1);
          else if (left < 2) flag_fault(o);
          else opt_pos = 6'd1;
        end else begin
          if (pos == 1) begin
            // length byte
            opt_len = b;
            if (b < 2 || b > left) begin
              flag_fault(opt_start);
            end else if (srcroute) begin
              if (b < 3) flag_fault(opt_start + 1);
            end else if (opt_kind == ipv4ov_pkg::OPT_RR) begin
              if (seen[ipv4ov_pkg::SEEN_RR]) flag_fault(opt_start);
              else if (b < 3) flag_fault(opt_start + 1);
            end else if (opt_kind == ipv4ov_pkg::OPT_TSTAMP) begin
              if (seen[ipv4ov_pkg::SEEN_TS]) flag_fault(opt_start);
              else if (b < 4) flag_fault(opt_start + 1);
            end
          end else if (pos == 2) begin
            // pointer byte
            opt_ptr = b;
            p = b;
            if (srcroute) begin
              if (p < 4) flag_fault(opt_start + 2);
              else if (seen[ipv4ov_pkg::SEEN_SRR]) flag_fault(opt_start);
              else seen[ipv4ov_pkg::SEEN_SRR] = 1'b1;
            end else if (opt_kind == ipv4ov_pkg::OPT_RR) begin
              if (p < 4) flag_fault(opt_start + 2);
              else if (p <= opt_len && p + 3 > opt_len) flag_fault(opt_start + 2);
              else seen[ipv4ov_pkg::SEEN_RR] = 1'b1;
            end else if (opt_kind == ipv4ov_pkg::OPT_TSTAMP) begin
              if (p < 5) flag_fault(opt_start + 2);
            end
          end else if (pos == 3 && opt_kind == ipv4ov_pkg::OPT_TSTAMP) begin
            // timestamp flags in the low nibble, overflow in the high nibble
            p = opt_ptr;
            if (p <= opt_len) begin
              if (p + 3 > opt_len) begin
                flag_fault(opt_start + 2);
              end else if (b[3:0] == ipv4ov_pkg::TSF_TIME_ONLY) begin
                seen[ipv4ov_pkg::SEEN_TS] = 1'b1;
              end else if (b[3:0] == ipv4ov_pkg::TSF_TIME_ADDR ||
                           b[3:0] == ipv4ov_pkg::TSF_PRESPEC) begin
                if (p + 7 > opt_len) flag_fault(opt_start + 2);
                else seen[ipv4ov_pkg::SEEN_TS] = 1'b1;
              end else begin
                flag_fault(opt_start + 3);
              end
            end else if (b[7:4] == ipv4ov_pkg::OVERFLOW_FULL) begin
              flag_fault(opt_start + 3);
            end else begin
              seen[ipv4ov_pkg::SEEN_TS] = 1'b1;
            end
          end
          // step to the next option once this one is consumed
          if (!parse_done) begin
            if (pos + 1 >= opt_len) begin
              opt_pos   = '0;
              opt_start = 6'(o + 1);
            end else begin
              opt_pos = 6'(pos + 1);
            end
          end
        end
      end
      byte_cnt = 6'(o + 1);
      if (byte_cnt == hdr_len) begin
        vdue = 1'b1;
        if (fault_at[6]) begin
          vres.verdict        = ipv4ov_pkg::VERDICT_MALFORMED;
          vres.problem_offset = fault_at[5:0];
        end else if (seen[ipv4ov_pkg::SEEN_SRR]) begin
          vres.verdict = ipv4ov_pkg::VERDICT_SRCROUTE;
        end else begin
          vres.verdict = ipv4ov_pkg::VERDICT_ACCEPT;
        end
      end
    end
  endtask

  // predict on accepted header bytes, compare on accepted verdict items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt = '0;
      hdr_len  = ipv4ov_pkg::HDR_MIN_BYTES;
      clear_parse();
      verdicts_due.delete();
      fails       = 0;
      n_accept    = 0;
      n_malformed = 0;
      n_srcroute  = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_byte(s_axis_tdata_i, s_axis_tuser_i, due, res);
        if (due) verdicts_due.push_back(res);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (verdicts_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected verdict item: verdict %0d offset %0d",
                     got.verdict, got.problem_offset);
        end else begin
          want = verdicts_due.pop_front();
          if (got.verdict !== want.verdict ||
              got.problem_offset !== want.problem_offset) begin
            fails++;
            if (fails <= 10)
              $display({"verdict mismatch: expected verdict %0d offset %0d,",
                        " got verdict %0d offset %0d"},
                       want.verdict, want.problem_offset, got.verdict,
                       got.problem_offset);
          end
          if (want.verdict == ipv4ov_pkg::VERDICT_MALFORMED) n_malformed++;
          else if (want.verdict == ipv4ov_pkg::VERDICT_SRCROUTE) n_srcroute++;
          else n_accept++;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= verdicts_due.size();
    accepted_o   <= n_accept;
    malformed_o  <= n_malformed;
    srcroute_o   <= n_srcroute;
  end

endmodule

/* sim/ipv4_options_validator_test.sv */
// top of the ipv4 options validator testbench: clock, reset, header stimulus
// and verdict sink with random stalls; depends on ipv4ov_pkg,
// ipv4_options_validator and ipv4ov_checker
`timescale 1ns / 100ps

module ipv4_options_validator_test;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES = 650;

  // short local names for option kinds and timestamp codes
  localparam logic [7:0] K_END     = ipv4ov_pkg::OPT_END;
  localparam logic [7:0] K_NOOP    = ipv4ov_pkg::OPT_NOOP;
  localparam logic [7:0] K_RR      = ipv4ov_pkg::OPT_RR;
  localparam logic [7:0] K_TS      = ipv4ov_pkg::OPT_TSTAMP;
  localparam logic [7:0] K_LSRR    = ipv4ov_pkg::OPT_LSRR;
  localparam logic [7:0] K_SSRR    = ipv4ov_pkg::OPT_SSRR;
  localparam logic [3:0] F_TONLY   = ipv4ov_pkg::TSF_TIME_ONLY;
  localparam logic [3:0] F_TADDR   = ipv4ov_pkg::TSF_TIME_ADDR;
  localparam logic [3:0] F_PRESPEC = ipv4ov_pkg::TSF_PRESPEC;
  localparam logic [3:0] OVF_FULL  = ipv4ov_pkg::OVERFLOW_FULL;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = '0;
  logic       s_tuser  = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  int unsigned fails, pending, n_accept, n_malformed, n_srcroute;
  int unsigned hdr_items   = 0;
  int unsigned stray_items = 0;
  int unsigned headers     = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned cycles      = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  logic [7:0]  hdr_opts[$];

  ipv4_options_validator u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  ipv4ov_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .accepted_o      (n_accept),
    .malformed_o     (n_malformed),
    .srcroute_o      (n_srcroute)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // verdict sink: short random stalls after each item, long holds on request
  initial begin
    int unsigned wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (m_tvalid && m_tready && !rx_steady) begin
        wait_n = $urandom_range(0, 3);
        if (wait_n != 0) begin
          m_tready <= 1'b0;
          repeat (wait_n) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // offer one byte after a random gap and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic f);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // send a header: random base fields, option area from hdr_opts padded with
  // noop; a nonzero cut stops the header early
  task automatic send_header(input logic [3:0] ihl, input logic mark_first,
                             input int unsigned cut);
    int unsigned total, i;
    logic [7:0] b;
    total = (ihl >= ipv4ov_pkg::IHL_MIN) ? ihl * 4 : ipv4ov_pkg::HDR_MIN_BYTES;
    if (cut != 0 && cut < total) total = cut;
    for (i = 0; i < total; i++) begin
      if (i == 0) b = {4'($urandom), ihl};
      else if (i < ipv4ov_pkg::HDR_MIN_BYTES) b = 8'($urandom);
      else if (i - ipv4ov_pkg::HDR_MIN_BYTES < hdr_opts.size())
        b = hdr_opts[i - ipv4ov_pkg::HDR_MIN_BYTES];
      else b = K_NOOP;
      send_byte(b, mark_first && i == 0);
    end
    hdr_items += total;
    headers++;
  endtask

  // random option area: mostly plausible options with random content
  task automatic build_options(input int unsigned room);
    int unsigned pick, len, left, ptr, emitted;
    logic [7:0] kind;
    logic [3:0] flags, ovf;
    hdr_opts.delete();
    while (hdr_opts.size() < room) begin
      left = room - hdr_opts.size();
      pick = $urandom_range(0, 11);
      if (pick < 2) begin
        hdr_opts.push_back(K_NOOP);
      end else if (pick == 2) begin
        hdr_opts.push_back(K_END);
      end else begin
        if (pick < 5) kind = K_RR;
        else if (pick < 7) kind = K_TS;
        else if (pick == 7) kind = K_LSRR;
        else if (pick == 8) kind = K_SSRR;
        else kind = 8'($urandom);
        len = ($urandom_range(0, 7) == 0 || left < 2) ? $urandom_range(0, 255)
                                                      : $urandom_range(2, left);
        if ($urandom_range(0, 5) == 0) ptr = $urandom_range(0, 255);
        else if (kind == K_TS) ptr = 5 + 4 * $urandom_range(0, len / 4);
        else ptr = 4 + 4 * $urandom_range(0, len / 4);
        hdr_opts.push_back(kind);
        hdr_opts.push_back(8'(len));
        hdr_opts.push_back(8'(ptr));
        emitted = 3;
        if (kind == K_TS) begin
          case ($urandom_range(0, 3))
            0:       flags = F_TONLY;
            1:       flags = F_TADDR;
            2:       flags = F_PRESPEC;
            default: flags = 4'($urandom);
          endcase
          ovf = ($urandom_range(0, 2) == 0) ? OVF_FULL : 4'($urandom);
          hdr_opts.push_back({ovf, flags});
          emitted = 4;
        end
        while (emitted < len && emitted < left) begin
          hdr_opts.push_back(8'($urandom));
          emitted++;
        end
      end
    end
    while (hdr_opts.size() > room) void'(hdr_opts.pop_back());
  endtask

  // stimulus and verdict
  initial begin
    int unsigned pick, room, cut, rnd_base, rnd_headers, i;
    logic [3:0] ihl;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // first byte after reset without the first flag
    hdr_opts.delete();
    send_header(4'd5, 1'b0, 0);
    // short ihl values
    send_header(4'd4, 1'b1, 0);
    send_header(4'd0, 1'b1, 0);
    // longest header, all noop
    send_header(4'd15, 1'b1, 0);
    // end of list followed by junk
    hdr_opts = '{K_END, 8'hFF, K_RR, 8'h00};
    send_header(4'd6, 1'b1, 0);
    // option kind on the last header byte
    hdr_opts = '{K_NOOP, K_NOOP, K_NOOP, K_RR};
    send_header(4'd6, 1'b1, 0);
    // length below two, length past the header end, all-ones option
    hdr_opts = '{8'h99, 8'd1, 8'h00, 8'h00};
    send_header(4'd6, 1'b1, 0);
    hdr_opts = '{8'h99, 8'd9, 8'h00, 8'h00};
    send_header(4'd6, 1'b1, 0);
    hdr_opts = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_header(4'd6, 1'b1, 0);
    // record route: good, pointer into the last slot, pointer too low, too short, twice
    hdr_opts = '{K_RR, 8'd7, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00, K_NOOP};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_RR, 8'd7, 8'd5, 8'h00, 8'h00, 8'h00, 8'h00, K_NOOP};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_RR, 8'd7, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, K_NOOP};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_RR, 8'd2, K_NOOP, K_NOOP};
    send_header(4'd6, 1'b1, 0);
    hdr_opts = '{K_RR, 8'd3, 8'd4, K_RR, 8'd3, 8'd4, K_NOOP, K_NOOP};
    send_header(4'd7, 1'b1, 0);
    // timestamp: each flag code, an unknown flag, overflow full and not full, twice
    hdr_opts = '{K_TS, 8'd8, 8'd5, {4'd0, F_TONLY},
                 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_TS, 8'd8, 8'd5, {4'd0, F_TADDR},
                 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_TS, 8'd12, 8'd5, {4'd0, F_PRESPEC},
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(4'd8, 1'b1, 0);
    hdr_opts = '{K_TS, 8'd8, 8'd5, {4'd0, 4'd2},
                 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_TS, 8'd8, 8'd9, {OVF_FULL, F_TONLY},
                 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_TS, 8'd8, 8'd9, {4'd1, F_TONLY},
                 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_TS, 8'd8, 8'd5, {4'd0, F_TONLY}, 8'h00, 8'h00,
                 8'h00, 8'h00, K_TS, 8'd8, 8'd5, {4'd0, F_TONLY},
                 8'h00, 8'h00, 8'h00, 8'h00};
    send_header(4'd9, 1'b1, 0);
    // source routes: loose alone, strict twice with an unknown option between
    hdr_opts = '{K_LSRR, 8'd7, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00, K_NOOP};
    send_header(4'd7, 1'b1, 0);
    hdr_opts = '{K_SSRR, 8'd3, 8'd4, 8'h55, 8'd2, K_SSRR, 8'd3, 8'd4};
    send_header(4'd7, 1'b1, 0);
    // restart in the middle of a header, then bytes past a header end
    hdr_opts.delete();
    send_header(4'd8, 1'b1, 10);
    send_header(4'd5, 1'b1, 0);
    for (i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);
    stray_items += 3;

    // random headers; two long output holds early on
    rnd_base    = hdr_items;
    rnd_headers = 0;
    while (hdr_items - rnd_base < RANDOM_BYTES || rnd_headers < 15) begin
      tx_steady <= ($urandom_range(0, 4) == 0);
      rx_steady <= ($urandom_range(0, 4) == 0);
      if (rnd_headers == 3 || rnd_headers == 12) holds_asked <= holds_asked + 1;
      pick = $urandom_range(0, 19);
      if (pick == 0) ihl = 4'($urandom_range(0, 4));
      else if (pick == 1) ihl = ipv4ov_pkg::IHL_MIN;
      else if (pick < 5) ihl = 4'($urandom_range(11, 15));
      else ihl = 4'($urandom_range(6, 10));
      room = (ihl >= ipv4ov_pkg::IHL_MIN) ? ihl * 4 - ipv4ov_pkg::HDR_MIN_BYTES : 0;
      build_options(room);
      cut = ($urandom_range(0, 15) == 0) ?
            $urandom_range(1, ipv4ov_pkg::HDR_MIN_BYTES + room - 1) : 0;
      send_header(ihl, 1'b1, cut);
      rnd_headers++;
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(1, 4);
        for (i = 0; i < pick; i++) send_byte(8'($urandom), 1'b0);
        stray_items += pick;
      end
    end

    // drain
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d headers: %0d header bytes, %0d stray bytes, two long output holds",
             headers, hdr_items, stray_items);
    $display("verdicts checked: %0d accepted, %0d malformed, %0d source route",
             n_accept, n_malformed, n_srcroute);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
